// ===== rtl/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg: shared types, constants and tables of the meter frame decoder
// Frame entry type carried between the front and back parts, result status
// codes, unit letters and the unit/range scale table.
// ----------------------------------------------------------------------------
package mfd_pkg;

	// frame delimiters and window geometry
	localparam logic [7:0] CHR_CR       = 8'h0D;
	localparam logic [7:0] CHR_LF       = 8'h0A;
	localparam int         WIN_DEPTH    = 10;
	localparam logic [3:0] COUNT_MAX    = 4'd15;
	localparam logic [3:0] FRAME_BYTES  = 4'd10;
	localparam int         QUEUE_DEPTH  = 2;

	// result status codes
	localparam logic [1:0] STATUS_UPDATED    = 2'd0;
	localparam logic [1:0] STATUS_MALFORMED  = 2'd1;
	localparam logic [1:0] STATUS_OVER_RANGE = 2'd2;

	// unit letters
	localparam logic [7:0] LETTER_V     = 8'h56;
	localparam logic [7:0] LETTER_A     = 8'h41;
	localparam logic [7:0] LETTER_O     = 8'h4F;
	localparam logic [7:0] LETTER_D     = 8'h44;
	localparam logic [7:0] LETTER_H     = 8'h48;
	localparam logic [7:0] LETTER_F     = 8'h46;
	localparam logic [7:0] LETTER_SPACE = 8'h20;

	// one frame as classified by the front part
	typedef struct packed {
		logic       short_frame;
		logic       over_range;
		logic       minus;
		logic [7:0] d0;
		logic [7:0] d1;
		logic [7:0] d2;
		logic [7:0] d3;
		logic [6:0] unit_code;
		logic [6:0] range_code;
	} mfd_frame_t;

	typedef struct packed {
		logic              known;
		logic signed [4:0] exponent;
	} mfd_scale_t;

	// power of ten for a unit/range pair
	function automatic mfd_scale_t scale_of(input logic [6:0] unit_code,
			input logic [6:0] range_code);
		mfd_scale_t s;
		logic [4:0] r;
		s.known    = 1'b0;
		s.exponent = 5'sd0;
		r          = {2'b00, range_code[2:0]};
		case (unit_code)
			7'd0, 7'd1: begin
				if (range_code <= 7'd4) begin
					s.known    = 1'b1;
					s.exponent = $signed(r - 5'd4);
				end
			end
			7'd2, 7'd3: begin
				if (range_code <= 7'd2) begin
					s.known    = 1'b1;
					s.exponent = $signed(r - 5'd6);
				end else if (range_code <= 7'd4) begin
					s.known    = 1'b1;
					s.exponent = -5'sd3;
				end
			end
			7'd4, 7'd5: begin
				if (range_code <= 7'd5) begin
					s.known    = 1'b1;
					s.exponent = $signed(r - 5'd1);
				end
			end
			7'd6: begin
				if (range_code <= 7'd1) begin
					s.known    = 1'b1;
					s.exponent = -5'sd3;
				end
			end
			7'd7, 7'd10: begin
				if (range_code <= 7'd2) begin
					s.known    = 1'b1;
					s.exponent = $signed(r + 5'd1);
				end else if (range_code == 7'd5) begin
					s.known    = 1'b1;
					s.exponent = -5'sd1;
				end else if (range_code == 7'd6) begin
					s.known    = 1'b1;
					s.exponent = 5'sd0;
				end
			end
			7'd8, 7'd9: begin
				if (range_code == 7'd0 || range_code == 7'd2) begin
					s.known    = 1'b1;
					s.exponent = -5'sd2;
				end
			end
			7'd12: begin
				if (range_code <= 7'd4) begin
					s.known    = 1'b1;
					s.exponent = $signed(r - 5'd12);
				end
			end
			default: begin
				s.known    = 1'b0;
				s.exponent = 5'sd0;
			end
		endcase
		return s;
	endfunction

	// ascii letter for a unit code
	function automatic logic [7:0] letter_of(input logic [6:0] unit_code);
		logic [7:0] l;
		case (unit_code)
			7'd0, 7'd1:               l = LETTER_V;
			7'd2, 7'd3, 7'd8, 7'd9:   l = LETTER_A;
			7'd4, 7'd5:               l = LETTER_O;
			7'd6:                     l = LETTER_D;
			7'd7, 7'd10:              l = LETTER_H;
			7'd12:                    l = LETTER_F;
			default:                  l = LETTER_SPACE;
		endcase
		return l;
	endfunction

endpackage

// ===== rtl/mfd_front.sv =====
// ----------------------------------------------------------------------------
// mfd_front: byte window and frame classifier
// Shifts received bytes into a ten-byte window, spots CR LF frame ends and
// pushes the fields of each frame into the queue.
// ----------------------------------------------------------------------------
module mfd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	output logic                push_valid,
	input  logic                push_ready,
	output mfd_pkg::mfd_frame_t push_data
);

	logic [7:0] win_q [mfd_pkg::WIN_DEPTH];
	logic [3:0] count_q;
	logic       accept;
	logic       frame_end;

	// frame end: LF straight after a CR in a non-empty window
	assign frame_end = (rx_byte == mfd_pkg::CHR_LF) && (count_q != 4'd0)
		&& (win_q[mfd_pkg::WIN_DEPTH-1] == mfd_pkg::CHR_CR);
	assign in_ready   = push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = in_valid && frame_end;

	// frame fields out of the window
	always_comb begin
		push_data.short_frame = (count_q < mfd_pkg::FRAME_BYTES);
		push_data.over_range  = win_q[0][0];
		push_data.minus       = win_q[0][3];
		push_data.d0          = win_q[1];
		push_data.d1          = win_q[2];
		push_data.d2          = win_q[3];
		push_data.d3          = win_q[4];
		push_data.unit_code   = win_q[5][6:0];
		push_data.range_code  = win_q[6][6:0];
	end

	// window shift and clear on frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mfd_pkg::WIN_DEPTH; i++) win_q[i] <= 8'd0;
			count_q <= 4'd0;
		end else if (accept) begin
			if (frame_end) begin
				for (int i = 0; i < mfd_pkg::WIN_DEPTH; i++) win_q[i] <= 8'd0;
				count_q <= 4'd0;
			end else begin
				for (int i = 0; i < mfd_pkg::WIN_DEPTH - 1; i++) win_q[i] <= win_q[i+1];
				win_q[mfd_pkg::WIN_DEPTH-1] <= rx_byte;
				if (count_q != mfd_pkg::COUNT_MAX) count_q <= count_q + 4'd1;
			end
		end
	end

endmodule

// ===== rtl/mfd_queue.sv =====
// ----------------------------------------------------------------------------
// mfd_queue: frame queue between front and back
// Small show-ahead queue of classified frames so that either side can stall.
// ----------------------------------------------------------------------------
module mfd_queue #(
	parameter int DEPTH = mfd_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  mfd_pkg::mfd_frame_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output mfd_pkg::mfd_frame_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mfd_pkg::mfd_frame_t entry_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    fill_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (fill_q != CNT_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == PTR_W'(DEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				if (rd_ptr_q == PTR_W'(DEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
		end
	end

endmodule

// ===== rtl/mfd_back.sv =====
// ----------------------------------------------------------------------------
// mfd_back: reading decoder and result register
// Takes a frame from the queue, updates the held reading if the frame is good
// and in range, and presents the result beat in an output register.
// ----------------------------------------------------------------------------
module mfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  mfd_pkg::mfd_frame_t pop_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          frame_status,
	output logic                reading_negative,
	output logic [18:0]         reading_magnitude,
	output logic signed [4:0]   reading_exponent,
	output logic                scale_known,
	output logic [7:0]          unit_letter
);

	logic                valid_q;
	logic                neg_q;
	logic [18:0]         mag_q;
	logic signed [4:0]   exp_q;
	logic                known_q;
	logic [7:0]          unit_q;
	logic [1:0]          status_q;
	logic                take;
	logic [18:0]         mag;
	mfd_pkg::mfd_scale_t scale;
	logic                update;

	assign pop_ready = !valid_q || out_ready;
	assign take      = pop_valid && pop_ready;
	assign update    = !pop_data.short_frame && !pop_data.over_range;

	// digit sum and scale lookup
	always_comb begin
		mag = 19'(pop_data.d0) + 19'(pop_data.d1) * 19'd10
			+ 19'(pop_data.d2) * 19'd100 + 19'(pop_data.d3) * 19'd1000;
		scale = mfd_pkg::scale_of(pop_data.unit_code, pop_data.range_code);
	end

	// held reading, updated only by a good in-range frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q   <= 1'b0;
			mag_q   <= '0;
			exp_q   <= '0;
			known_q <= 1'b0;
			unit_q  <= mfd_pkg::LETTER_SPACE;
		end else if (take && update) begin
			unit_q  <= mfd_pkg::letter_of(pop_data.unit_code);
			known_q <= scale.known;
			if (scale.known) begin
				mag_q <= mag;
				exp_q <= scale.exponent;
				neg_q <= pop_data.minus && (mag != 19'd0);
			end else begin
				mag_q <= '0;
				exp_q <= '0;
				neg_q <= 1'b0;
			end
		end
	end

	// result status
	always_ff @(posedge clk) begin
		if (take) begin
			if (pop_data.short_frame) status_q <= mfd_pkg::STATUS_MALFORMED;
			else if (pop_data.over_range) status_q <= mfd_pkg::STATUS_OVER_RANGE;
			else status_q <= mfd_pkg::STATUS_UPDATED;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (take) valid_q <= 1'b1;
		else if (out_ready) valid_q <= 1'b0;
	end

	assign out_valid         = valid_q;
	assign frame_status      = status_q;
	assign reading_negative  = neg_q;
	assign reading_magnitude = mag_q;
	assign reading_exponent  = exp_q;
	assign scale_known       = known_q;
	assign unit_letter       = unit_q;

endmodule

// ===== rtl/meter_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// meter_frame_decoder_unit: multimeter serial frame decoder
// Accepts one received byte per cycle while the frame queue has room; each CR LF frame end gives one result.
// ----------------------------------------------------------------------------
// result path: the edge that accepts the LF pushes the frame into the queue; the back then loads the result register
// throughput: one byte per cycle while the queue has room, one result per cycle while out_ready holds
// the frame queue (QUEUE_DEPTH entries) sets how long the back may stall
// before in_ready drops
// reset: window, byte count, queue and result valid clear; held reading is
// zero with unit letter space
module meter_frame_decoder_unit #(
	parameter int QUEUE_DEPTH = mfd_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        frame_status,
	output logic              reading_negative,
	output logic [18:0]       reading_magnitude,
	output logic signed [4:0] reading_exponent,
	output logic              scale_known,
	output logic [7:0]        unit_letter
);

	logic                push_valid;
	logic                push_ready;
	mfd_pkg::mfd_frame_t push_data;
	logic                pop_valid;
	logic                pop_ready;
	mfd_pkg::mfd_frame_t pop_data;

	// byte window and frame classifier
	mfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// frame queue
	mfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// reading decoder
	mfd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.pop_valid         (pop_valid),
		.pop_ready         (pop_ready),
		.pop_data          (pop_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.frame_status      (frame_status),
		.reading_negative  (reading_negative),
		.reading_magnitude (reading_magnitude),
		.reading_exponent  (reading_exponent),
		.scale_known       (scale_known),
		.unit_letter       (unit_letter)
	);

	// a beat that leaves the reading alone repeats the previous beat's reading
	a_held_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid && frame_status != mfd_pkg::STATUS_UPDATED
		|-> $stable(reading_magnitude) && $stable(reading_exponent)
			&& $stable(unit_letter) && $stable(reading_negative))
		else $error("held reading changed without an updating frame");

	// unknown scale means a zero value with no sign
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !scale_known
		|-> reading_magnitude == 19'd0 && reading_exponent == 5'sd0 && !reading_negative)
		else $error("unknown scale with non-zero reading");

	// a negative reading is never zero
	a_neg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reading_negative |-> reading_magnitude != 19'd0)
		else $error("negative zero reading");

	// a frame end is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |-> !(in_valid && in_ready))
		else $error("frame end accepted with the queue full");

endmodule
